// ----- rtl/haptic_velocity_estimator_assert.svh -----
// Assertion macros for the haptic velocity estimator checks
`ifndef HAPTIC_VELOCITY_ESTIMATOR_ASSERT_SVH
`define HAPTIC_VELOCITY_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define HVE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hve check failed");

// next-cycle implication
`define HVE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hve check failed");

`endif

// ----- rtl/hve_pkg.sv -----
// Types and constants shared by the haptic velocity estimator modules
package hve_pkg;

   localparam int POS_W   = 26;
   localparam int VEL_W   = 29;
   localparam int RAW_W   = 40;
   localparam int DIFF_W  = 30;
   localparam int RATE_W  = 16;
   localparam int FFG_W   = 32;
   localparam int FBG_W   = 33;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 68;
   localparam int ACC_W   = 80;
   localparam int SPLIT_W = 24;
   localparam int SUM_W   = 41;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 33;

   localparam logic [CSR_IDX_W-1:0] REG_OUTER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FB1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB3   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE  = 3'd5;

   localparam logic [FFG_W-1:0]        OUTER_RST = 32'd943175;
   localparam logic [FFG_W-1:0]        INNER_RST = 32'd2829525;
   localparam logic signed [FBG_W-1:0] FB1_RST   = -33'sd2951501526;
   localparam logic signed [FBG_W-1:0] FB2_RST   = 33'sd2714634079;
   localparam logic signed [FBG_W-1:0] FB3_RST   = -33'sd834941642;
   localparam logic [RATE_W-1:0]       RATE_RST  = 16'd500;

   localparam logic signed [RAW_W-1:0] RAW_MAX = 40'sh7FFFFFFFFF;
   localparam logic signed [RAW_W-1:0] RAW_MIN = 40'sh8000000000;
   localparam logic signed [VEL_W-1:0] VEL_MAX = 29'sh0FFFFFFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 29'sh10000000;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 80'sd2147483648;

   // multiplier operand selects
   localparam logic [2:0] MS_RATE     = 3'd0;
   localparam logic [2:0] MS_FB1      = 3'd1;
   localparam logic [2:0] MS_FB2      = 3'd2;
   localparam logic [2:0] MS_FB3      = 3'd3;
   localparam logic [2:0] MS_INNER_LO = 3'd4;
   localparam logic [2:0] MS_INNER_HI = 3'd5;
   localparam logic [2:0] MS_OUTER_LO = 3'd6;
   localparam logic [2:0] MS_OUTER_HI = 3'd7;

   // accumulator operations
   localparam logic [2:0] AO_HOLD   = 3'd0;
   localparam logic [2:0] AO_INIT   = 3'd1;
   localparam logic [2:0] AO_SUB4   = 3'd2;
   localparam logic [2:0] AO_ADD_LO = 3'd3;
   localparam logic [2:0] AO_ADD_HI = 3'd4;

   typedef struct packed {
      logic [2:0] mul_sel;
      logic [2:0] acc_op;
      logic       raw_cap;
      logic       axis_end;
      logic       publish;
   } hve_ctl_type;

   typedef struct packed {
      logic signed [POS_W-1:0] p1;
      logic signed [POS_W-1:0] p2;
      logic signed [RAW_W-1:0] r1;
      logic signed [RAW_W-1:0] r2;
      logic signed [RAW_W-1:0] r3;
      logic signed [VEL_W-1:0] y1;
      logic signed [VEL_W-1:0] y2;
      logic signed [VEL_W-1:0] y3;
   } hve_hist_type;

endpackage

// ----- rtl/haptic_velocity_estimator.sv -----
// Top level of the haptic velocity estimator
// A single 34x34 multiplier runs ten steps per axis, and the request side stays
// closed until the result is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset: histories clear to zero, coefficients return to defaults; csr is always ready.
module haptic_velocity_estimator import hve_pkg::*; #(
   parameter int AXES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((POS_W*AXES+7)/8)*8-1:0]   req_tdata,   // pos_x, pos_y, pos_z, ...
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((VEL_W*AXES+7)/8)*8-1:0]   rsp_tdata,   // vel_x, vel_y, vel_z, ...
   output logic                              rsp_tuser,   // clipped
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_data
);

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int RSP_W  = ((VEL_W*AXES+7)/8)*8;

   logic [FFG_W-1:0]        outer_ff, inner_ff;
   logic signed [FBG_W-1:0] fb1_ff, fb2_ff, fb3_ff;
   logic [RATE_W-1:0]       rate_ff;

   logic signed [POS_W-1:0] pos_ff [AXES];
   hve_hist_type            hist_ff [AXES];
   logic signed [VEL_W-1:0] vel_ff [AXES];
   logic signed [RAW_W-1:0] raw_ff;
   logic                    clip_ff;
   logic                    rsp_valid_ff;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_pack;
   logic                    rsp_clip_ff;

   logic                    accept, pub_ok;
   logic [AXIS_W-1:0]       axis;
   hve_ctl_type             ctl;

   logic signed [POS_W-1:0]  cur_pos;
   hve_hist_type             cur_hist;
   logic signed [DIFF_W-1:0] pos_e, p1_e, p2_e, diff;
   logic signed [SUM_W-1:0]  sum_inner, sum_outer;
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   logic                     raw_ovf, y_ovf;
   logic signed [RAW_W-1:0]  raw_sat;
   logic signed [VEL_W-1:0]  y_sat;

   assign accept    = req_tvalid && req_tready;
   assign pub_ok    = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   hve_ctrl #(.AXES(AXES), .AXIS_W(AXIS_W)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .pub_ok (pub_ok),
      .ready  (req_tready),
      .axis   (axis),
      .ctl    (ctl)
   );

   hve_mac u_mac (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .acc_op (ctl.acc_op),
      .prod   (prod),
      .acc    (acc)
   );

   assign cur_pos  = pos_ff[axis];
   assign cur_hist = hist_ff[axis];

   assign pos_e = $signed({{(DIFF_W-POS_W){cur_pos[POS_W-1]}}, cur_pos});
   assign p1_e  = $signed({{(DIFF_W-POS_W){cur_hist.p1[POS_W-1]}}, cur_hist.p1});
   assign p2_e  = $signed({{(DIFF_W-POS_W){cur_hist.p2[POS_W-1]}}, cur_hist.p2});
   assign diff  = (pos_e <<< 1) + pos_e - (p1_e <<< 2) + p2_e;

   assign sum_inner = $signed({cur_hist.r1[RAW_W-1], cur_hist.r1})
                    + $signed({cur_hist.r2[RAW_W-1], cur_hist.r2});
   assign sum_outer = $signed({raw_ff[RAW_W-1], raw_ff})
                    + $signed({cur_hist.r3[RAW_W-1], cur_hist.r3});

   always_comb begin
      case (ctl.mul_sel)
         MS_RATE: begin
            op_a = $signed({{(MUL_W-DIFF_W){diff[DIFF_W-1]}}, diff});
            op_b = $signed({{(MUL_W-RATE_W){1'b0}}, rate_ff});
         end
         MS_FB1: begin
            op_a = $signed({fb1_ff[FBG_W-1], fb1_ff});
            op_b = $signed({{(MUL_W-VEL_W){cur_hist.y1[VEL_W-1]}}, cur_hist.y1});
         end
         MS_FB2: begin
            op_a = $signed({fb2_ff[FBG_W-1], fb2_ff});
            op_b = $signed({{(MUL_W-VEL_W){cur_hist.y2[VEL_W-1]}}, cur_hist.y2});
         end
         MS_FB3: begin
            op_a = $signed({fb3_ff[FBG_W-1], fb3_ff});
            op_b = $signed({{(MUL_W-VEL_W){cur_hist.y3[VEL_W-1]}}, cur_hist.y3});
         end
         MS_INNER_LO: begin
            op_a = $signed({{(MUL_W-FFG_W){1'b0}}, inner_ff});
            op_b = $signed({{(MUL_W-SPLIT_W){1'b0}}, sum_inner[SPLIT_W-1:0]});
         end
         MS_INNER_HI: begin
            op_a = $signed({{(MUL_W-FFG_W){1'b0}}, inner_ff});
            op_b = $signed({{(MUL_W-SUM_W+SPLIT_W){sum_inner[SUM_W-1]}},
                            sum_inner[SUM_W-1:SPLIT_W]});
         end
         MS_OUTER_LO: begin
            op_a = $signed({{(MUL_W-FFG_W){1'b0}}, outer_ff});
            op_b = $signed({{(MUL_W-SPLIT_W){1'b0}}, sum_outer[SPLIT_W-1:0]});
         end
         MS_OUTER_HI: begin
            op_a = $signed({{(MUL_W-FFG_W){1'b0}}, outer_ff});
            op_b = $signed({{(MUL_W-SUM_W+SPLIT_W){sum_outer[SUM_W-1]}},
                            sum_outer[SUM_W-1:SPLIT_W]});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign raw_ovf = (|prod[PROD_W-1:RAW_W-1]) && !(&prod[PROD_W-1:RAW_W-1]);
   assign raw_sat = raw_ovf ? (prod[PROD_W-1] ? RAW_MIN : RAW_MAX) : prod[RAW_W-1:0];

   assign y_ovf = (|acc[ACC_W-1:60]) && !(&acc[ACC_W-1:60]);
   assign y_sat = y_ovf ? (acc[ACC_W-1] ? VEL_MIN : VEL_MAX) : acc[60:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff <= OUTER_RST;
         inner_ff <= INNER_RST;
         fb1_ff   <= FB1_RST;
         fb2_ff   <= FB2_RST;
         fb3_ff   <= FB3_RST;
         rate_ff  <= RATE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OUTER: outer_ff <= csr_data[FFG_W-1:0];
            REG_INNER: inner_ff <= csr_data[FFG_W-1:0];
            REG_FB1:   fb1_ff   <= $signed(csr_data[FBG_W-1:0]);
            REG_FB2:   fb2_ff   <= $signed(csr_data[FBG_W-1:0]);
            REG_FB3:   fb3_ff   <= $signed(csr_data[FBG_W-1:0]);
            REG_RATE:  rate_ff  <= csr_data[RATE_W-1:0];
            default:   rate_ff  <= rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int a = 0; a < AXES; a++) begin
            pos_ff[a] <= $signed(req_tdata[a*POS_W +: POS_W]);
         end
      end
      if (ctl.raw_cap) begin
         raw_ff <= raw_sat;
      end
      if (ctl.axis_end) begin
         vel_ff[axis] <= y_sat;
      end
      if (ctl.publish) begin
         rsp_data_ff <= rsp_pack;
         rsp_clip_ff <= clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            hist_ff[a] <= '0;
         end
      end else if (ctl.axis_end) begin
         hist_ff[axis].p2 <= cur_hist.p1;
         hist_ff[axis].p1 <= cur_pos;
         hist_ff[axis].r3 <= cur_hist.r2;
         hist_ff[axis].r2 <= cur_hist.r1;
         hist_ff[axis].r1 <= raw_ff;
         hist_ff[axis].y3 <= cur_hist.y2;
         hist_ff[axis].y2 <= cur_hist.y1;
         hist_ff[axis].y1 <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            clip_ff <= 1'b0;
         end else if ((ctl.raw_cap && raw_ovf) || (ctl.axis_end && y_ovf)) begin
            clip_ff <= 1'b1;
         end
         if (ctl.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_pack = '0;
      for (int a = 0; a < AXES; a++) begin
         rsp_pack[a*VEL_W +: VEL_W] = vel_ff[a];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule

// ----- rtl/hve_mac.sv -----
// Shared signed multiplier with registered product and shifting accumulator
module hve_mac import hve_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   input  logic [2:0]               acc_op,
   output logic signed [PROD_W-1:0] prod,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_in  = op_a * op_b;
   assign prod_ext = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});

   always_comb begin
      case (acc_op)
         AO_INIT:   acc_in = ROUND_HALF - (prod_ext <<< 2);
         AO_SUB4:   acc_in = acc_ff - (prod_ext <<< 2);
         AO_ADD_LO: acc_in = acc_ff + prod_ext;
         AO_ADD_HI: acc_in = acc_ff + (prod_ext <<< SPLIT_W);
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

// ----- rtl/hve_ctrl.sv -----
// Sequencer stepping the shared multiplier through each axis
module hve_ctrl import hve_pkg::*; #(
   parameter int AXES   = 3,
   parameter int AXIS_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              pub_ok,
   output logic              ready,
   output logic [AXIS_W-1:0] axis,
   output hve_ctl_type       ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_PUB  = 2'd2;

   localparam logic [3:0] SQ_RATE     = 4'd0;
   localparam logic [3:0] SQ_FB1      = 4'd1;
   localparam logic [3:0] SQ_FB2      = 4'd2;
   localparam logic [3:0] SQ_FB3      = 4'd3;
   localparam logic [3:0] SQ_INNER_LO = 4'd4;
   localparam logic [3:0] SQ_INNER_HI = 4'd5;
   localparam logic [3:0] SQ_OUTER_LO = 4'd6;
   localparam logic [3:0] SQ_OUTER_HI = 4'd7;
   localparam logic [3:0] SQ_TAIL     = 4'd8;
   localparam logic [3:0] SQ_FINAL    = 4'd9;

   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

   logic [1:0]        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = SQ_RATE;
               axis_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == SQ_FINAL) begin
               step_in = SQ_RATE;
               if (axis_ff == AXIS_LAST) begin
                  state_in = ST_PUB;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PUB: begin
            if (pub_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= SQ_RATE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      ctl         = '0;
      ctl.mul_sel = MS_RATE;
      ctl.acc_op  = AO_HOLD;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            SQ_RATE: ctl.mul_sel = MS_RATE;
            SQ_FB1: begin
               ctl.mul_sel = MS_FB1;
               ctl.raw_cap = 1'b1;
            end
            SQ_FB2: begin
               ctl.mul_sel = MS_FB2;
               ctl.acc_op  = AO_INIT;
            end
            SQ_FB3: begin
               ctl.mul_sel = MS_FB3;
               ctl.acc_op  = AO_SUB4;
            end
            SQ_INNER_LO: begin
               ctl.mul_sel = MS_INNER_LO;
               ctl.acc_op  = AO_SUB4;
            end
            SQ_INNER_HI: begin
               ctl.mul_sel = MS_INNER_HI;
               ctl.acc_op  = AO_ADD_LO;
            end
            SQ_OUTER_LO: begin
               ctl.mul_sel = MS_OUTER_LO;
               ctl.acc_op  = AO_ADD_HI;
            end
            SQ_OUTER_HI: begin
               ctl.mul_sel = MS_OUTER_HI;
               ctl.acc_op  = AO_ADD_LO;
            end
            SQ_TAIL:  ctl.acc_op   = AO_ADD_HI;
            SQ_FINAL: ctl.axis_end = 1'b1;
            default:  ctl.acc_op   = AO_HOLD;
         endcase
      end
      if (state_ff == ST_PUB) begin
         ctl.publish = pub_ok;
      end
   end

   assign ready = (state_ff == ST_IDLE);
   assign axis  = axis_ff;

endmodule

// ----- rtl/hve_checker.sv -----
// Port-level checks for the haptic velocity estimator, bound to the top level
`include "haptic_velocity_estimator_assert.svh"

module hve_checker import hve_pkg::*; #(
   parameter int AXES = 3
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((VEL_W*AXES+7)/8)*8-1:0]   rsp_tdata,   // vel_x, vel_y, vel_z, ...
   input logic                              rsp_tuser,   // clipped
   input logic                              csr_valid,
   input logic                              csr_ready
);

   `HVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `HVE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready && !$rose(rsp_tvalid))
   `HVE_ASSERT_IMP(a_result_reopens, clock, reset, $rose(rsp_tvalid), req_tready && !$past(req_tready))
   `HVE_ASSERT_IMP(a_csr_open, clock, reset, csr_valid, csr_ready)

endmodule

bind haptic_velocity_estimator hve_checker #(.AXES(AXES)) u_hve_checker (.*);
